// ===== rtl/core/gemm_pkg.sv =====
package gemm_pkg;

  localparam int unsigned Rows = 4;
  localparam int unsigned Cols = 4;
  localparam int unsigned RowW = 2;
  localparam int unsigned ColW = 2;
  localparam logic [31:0] QNan = 32'h7FC0_0000;
  localparam logic [31:0] AlphaReset = 32'h3F80_0000;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdLoad  = 2'd1,
    CmdAccum = 2'd2,
    CmdWback = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegAlpha = 2'd0,
    RegRows  = 2'd1,
    RegCols  = 2'd2
  } reg_e;

  // Request to the shared floating-point unit.
  typedef struct packed {
    logic        mul;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

endpackage

// ===== rtl/core/gemm_fpu.sv =====
// Shared binary32 unit: one multiply or one add per request, round to nearest even.
// The exact product or sum is normalized and registered, then rounded in the
// next cycle, so the result is valid in the cycle after the request.
module gemm_fpu
  import gemm_pkg::*;
(
  input  logic     clk_i,
  input  fpu_req_t req_i,
  output logic [31:0] res_o
);

  logic [31:0] res;

  // Multiply path signals.
  logic        sa, sb, sr;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [47:0] prod;
  logic [47:0] pn;
  logic signed [10:0] pe;
  logic [5:0]  lz;

  // Add path signals.
  logic [31:0] big, sml;
  logic [7:0]  eb2, es2;
  logic [26:0] mbig, msml, msh;
  logic [7:0]  dexp;
  logic        sticky;
  logic [27:0] sum;
  logic [27:0] sn;
  logic signed [10:0] se;
  logic [4:0]  lz2;

  // Rounding stage input: 27-bit mantissa with guard and sticky.
  logic [26:0] rm, rm_q;
  logic signed [10:0] re, re_q;
  logic        rs, rs_q;
  logic        special, special_q;
  logic [31:0] spec_val, spec_val_q;
  logic [26:0] den;
  logic [9:0]  shamt;
  logic        st2;
  logic [24:0] rounded;
  logic signed [10:0] fe;

  // Front end before the register: special values, exact product or aligned sum, normalization.
  always_comb begin
    sa = req_i.a[31]; ea = req_i.a[30:23]; fa = req_i.a[22:0];
    sb = req_i.b[31]; eb = req_i.b[30:23]; fb = req_i.b[22:0];
    a_nan = (ea == 8'hFF) && (fa != 23'd0);
    b_nan = (eb == 8'hFF) && (fb != 23'd0);
    a_inf = (ea == 8'hFF) && (fa == 23'd0);
    b_inf = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    prod = '0; pn = '0; pe = '0; lz = '0;
    big = '0; sml = '0; eb2 = '0; es2 = '0; mbig = '0; msml = '0; msh = '0;
    dexp = '0; sticky = 1'b0; sum = '0; sn = '0; se = '0; lz2 = '0;
    special = 1'b0; spec_val = '0; rm = '0; re = '0; rs = 1'b0;
    if (req_i.mul) begin
      sr = sa ^ sb;
      rs = sr;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        special = 1'b1; spec_val = QNan;
      end else if (a_inf || b_inf) begin
        special = 1'b1; spec_val = {sr, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
        special = 1'b1; spec_val = {sr, 31'd0};
      end else begin
        prod = ma * mb;
        // Normalize so bit 47 is the leading one.
        lz = '0;
        for (int i = 0; i < 48; i++) begin
          if (prod[i]) lz = 6'(47 - i);
        end
        pn = prod << lz;
        pe = 11'(ea == 8'd0 ? 1 : ea) + 11'(eb == 8'd0 ? 1 : eb) - 11'sd126
             - 11'(lz);
        rm = {pn[47:22], (pn[21:0] != 22'd0)};
        re = pe;
      end
    end else begin
      sr = 1'b0;
      if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
        special = 1'b1; spec_val = QNan;
      end else if (a_inf) begin
        special = 1'b1; spec_val = req_i.a;
      end else if (b_inf) begin
        special = 1'b1; spec_val = req_i.b;
      end else begin
        if (req_i.a[30:0] >= req_i.b[30:0]) begin
          big = req_i.a; sml = req_i.b;
        end else begin
          big = req_i.b; sml = req_i.a;
        end
        eb2 = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es2 = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        msml = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        dexp = eb2 - es2;
        if (dexp > 8'd26) begin
          msh = 27'd0; sticky = (msml != 27'd0);
        end else begin
          msh = msml >> dexp;
          sticky = ((msh << dexp) != msml);
        end
        msh[0] = msh[0] | sticky;
        if (big[31] == sml[31]) sum = {1'b0, mbig} + {1'b0, msh};
        else sum = {1'b0, mbig} - {1'b0, msh};
        if (sum == 28'd0) begin
          special = 1'b1;
          spec_val = {(sa & sb), 31'd0};
        end else begin
          lz2 = '0;
          for (int i = 0; i < 28; i++) begin
            if (sum[i]) lz2 = 5'(27 - i);
          end
          sn = sum << lz2;
          se = 11'(eb2) + 11'sd1 - 11'(lz2);
          rm = {sn[27:2], (sn[1:0] != 2'd0)};
          re = se;
          rs = big[31];
        end
      end
    end
  end

  // Normalized value held for the rounding cycle.
  always_ff @(posedge clk_i) begin
    special_q <= special;
    spec_val_q <= spec_val;
    rm_q <= rm;
    re_q <= re;
    rs_q <= rs;
  end

  // After the register: denormalize, round and pack.
  always_comb begin
    // Denormalize when the exponent falls below one.
    if (re_q < 11'sd1) begin
      shamt = 10'(11'sd1 - re_q);
      if (shamt > 10'd26) begin
        den = 27'd0; st2 = (rm_q != 27'd0);
      end else begin
        den = rm_q >> shamt;
        st2 = ((den << shamt) != rm_q);
      end
      den[0] = den[0] | st2;
      fe = 11'sd0;
    end else begin
      shamt = '0; st2 = 1'b0; den = rm_q; fe = re_q;
    end
    rounded = {1'b0, den[26:3]} +
              25'(den[2] && (den[1] || den[0] || den[3]));
    if (special_q) begin
      res = spec_val_q;
    end else if (rounded[24]) begin
      // Carry out of rounding.
      fe = fe + 11'sd1;
      res = (fe >= 11'sd255) ? {rs_q, 8'hFF, 23'd0} : {rs_q, fe[7:0], rounded[23:1]};
    end else if (fe == 11'sd0) begin
      res = {rs_q, 7'd0, rounded[23], rounded[22:0]};
    end else if (fe >= 11'sd255) begin
      res = {rs_q, 8'hFF, 23'd0};
    end else begin
      res = {rs_q, fe[7:0], rounded[22:0]};
    end
  end

  assign res_o = res;

endmodule

// ===== rtl/core/gemm_outer_product_tile_mac_unit.sv =====
// GEMM tile multiply-accumulate unit, binary32.
// Items enter on start_i/command_i/operand_i/row_i/col_i while busy_o is low.
// Commands: clear the tile, load one B element, accumulate one A element into
// a tile row, or write back one C element as acc*alpha + C.
// Configuration (alpha, rows in use, cols in use) is written through
// cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i while idle.
// Clear and load complete while busy_o stays low. Accumulate uses one shared float
// unit, multiply then add for each active column (StMul, StMulWait, StAdd,
// StAddWait per column). An in-range write back keeps busy_o high through these
// states and raises valid_o with c_out_o/in_range_o in the cycle in which busy_o
// falls; an out-of-range write back returns the old C in the cycle after it is accepted.
// The receiver cannot stall; results are never held.
// Reset sets alpha to 1.0, both in-use limits to 4 and clears the tile.
module gemm_outer_product_tile_mac_unit
  import gemm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] operand_i,
  input  logic [1:0]  row_i,
  input  logic [1:0]  col_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic [31:0] c_out_o,
  output logic        in_range_o
);

  typedef enum logic [2:0] {
    StIdle, StMul, StMulWait, StAdd, StAddWait
  } state_e;

  state_e state_q;
  logic [31:0] acc_q [Rows*Cols];
  logic [31:0] b_q [Cols];
  logic [31:0] alpha_q, opnd_q, prod_q, fres;
  logic [2:0]  rows_q, cols_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q, lim_q;
  logic        wb_q, valid_q, inr_q;
  logic [31:0] cout_q;
  fpu_req_t    req;
  logic        row_ok, col_ok;
  logic [3:0]  idx;

  assign row_ok = ({1'b0, row_i} < rows_q);
  assign col_ok = ({1'b0, col_i} < cols_q);
  assign idx = {row_q, col_q};

  // Operand selection for the shared unit.
  always_comb begin
    req.mul = (state_q == StMul);
    if (state_q == StMul) begin
      req.a = wb_q ? acc_q[idx] : opnd_q;
      req.b = wb_q ? alpha_q : b_q[col_q];
    end else begin
      req.a = prod_q;
      req.b = wb_q ? opnd_q : acc_q[idx];
    end
  end

  gemm_fpu u_fpu (.clk_i, .req_i(req), .res_o(fres));

  // Sequencer, tile and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      alpha_q <= AlphaReset;
      rows_q <= 3'd4;
      cols_q <= 3'd4;
      valid_q <= 1'b0;
      for (int i = 0; i < Rows*Cols; i++) acc_q[i] <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              RegAlpha: alpha_q <= cfg_data_i;
              RegRows:  rows_q <= cfg_data_i[2:0];
              RegCols:  cols_q <= cfg_data_i[2:0];
              default: ;
            endcase
          end
          if (start_i) begin
            opnd_q <= operand_i;
            row_q <= row_i;
            case (cmd_e'(command_i))
              CmdClear: for (int i = 0; i < Rows*Cols; i++) acc_q[i] <= '0;
              CmdLoad: b_q[col_i] <= operand_i;
              CmdAccum: begin
                if (row_ok && cols_q != 3'd0) begin
                  wb_q <= 1'b0;
                  col_q <= '0;
                  lim_q <= (cols_q > 3'd4) ? 2'd3 : 2'(cols_q - 3'd1);
                  state_q <= StMul;
                end
              end
              CmdWback: begin
                if (row_ok && col_ok) begin
                  wb_q <= 1'b1;
                  col_q <= col_i;
                  state_q <= StMul;
                end else begin
                  valid_q <= 1'b1;
                  cout_q <= operand_i;
                  inr_q <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        StMul: state_q <= StMulWait;
        StMulWait: begin
          prod_q <= fres;
          state_q <= StAdd;
        end
        StAdd: state_q <= StAddWait;
        StAddWait: begin
          if (wb_q) begin
            valid_q <= 1'b1;
            cout_q <= fres;
            inr_q <= 1'b1;
            state_q <= StIdle;
          end else begin
            acc_q[idx] <= fres;
            if (col_q == lim_q) state_q <= StIdle;
            else begin
              col_q <= col_q + 2'd1;
              state_q <= StMul;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign valid_o = valid_q;
  assign c_out_o = cout_q;
  assign in_range_o = inr_q;

endmodule
